### design/jpeg_huffman_block_encoder_unit_defines.svh
// Assertion macros used by the encoder's back end.
// Depends on nothing; include by bare file name.
`ifndef JPEG_HUFFMAN_BLOCK_ENCODER_UNIT_DEFINES_SVH
`define JPEG_HUFFMAN_BLOCK_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JHE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("encoder check failed in the same cycle");

// Next-cycle implication, disabled while reset is asserted.
`define JHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("encoder check failed one cycle later");

`endif

### design/jhe_pkg.sv
// Shared types and constants of the block Huffman encoder.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
package jhe_pkg;

	localparam logic [2:0] CMD_LOAD_DC = 3'd0;
	localparam logic [2:0] CMD_LOAD_AC = 3'd1;
	localparam logic [2:0] CMD_ENC_DC  = 3'd2;
	localparam logic [2:0] CMD_ENC_AC  = 3'd3;
	localparam logic [2:0] CMD_END     = 3'd4;

	localparam int CODE_W   = 16;
	localparam int LEN_W    = 5;
	localparam int AMP_W    = 11;
	localparam int CAT_W    = 4;
	localparam int PEND_W   = 7;
	localparam int CNT_W    = 10;
	// Seven pending bits, the longest code and the longest amplitude.
	localparam int ACC_W    = PEND_W + CODE_W + AMP_W;
	localparam int ACC_CW   = 6;

	localparam logic [3:0] RUN_MAX    = 4'd15;
	localparam logic [3:0] AC_CAT_MAX = 4'd10;
	localparam logic [3:0] DC_CAT_MAX = 4'd11;
	localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_END,
		KIND_DC,
		KIND_AC
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} back_state_t;

	// One classified symbol, ready to be packed into the bit stream.
	typedef struct packed {
		logic              is_end;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  code_len;
		logic [AMP_W-1:0]  amp;
		logic [CAT_W-1:0]  amp_len;
	} qent_t;

endpackage

### design/jhe_in_if.sv
// Input channel of the encoder: valid/ready handshake and the item fields.
// No dependencies.
interface jhe_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [7:0]         table_index;
	logic [15:0]        table_code;
	logic [4:0]         table_length;
	logic [5:0]         zero_run;
	logic signed [11:0] value;

	modport source (output valid, cmd, table_index, table_code, table_length, zero_run,
		value, input ready);
	modport sink (input valid, cmd, table_index, table_code, table_length, zero_run,
		value, output ready);
endinterface

### design/jhe_out_if.sv
// Result channel of the encoder: valid/ready handshake and the result fields.
// No dependencies.
interface jhe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic       block_done;
	logic [9:0] block_byte_count;

	modport source (output valid, out_byte, byte_valid, last, block_done,
		block_byte_count, input ready);
	modport sink (input valid, out_byte, byte_valid, last, block_done,
		block_byte_count, output ready);
endinterface

### design/jhe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module jhe_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/jhe_front.sv
// Front end: accepts items, loads the code tables, classifies symbols and
// looks up their codes. Depends on jhe_pkg, jhe_in_if and jhe_ram.
module jhe_front #(
	parameter int AC_TABLE_DEPTH  = 256,
	parameter int DC_TABLE_DEPTH  = 12,
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	jhe_in_if.sink        items,
	output logic          push_valid,
	input  logic          push_ready,
	output jhe_pkg::qent_t push_data
);

	localparam int DC_AW = $clog2(DC_TABLE_DEPTH);
	localparam int AC_AW = $clog2(AC_TABLE_DEPTH);
	localparam int ENT_W = MAX_CODE_LENGTH + jhe_pkg::LEN_W;

	function automatic logic [jhe_pkg::CAT_W-1:0] bit_len(input logic [jhe_pkg::AMP_W-1:0] a);
		logic [jhe_pkg::CAT_W-1:0] c;
		c = '0;
		for (int i = 0; i < jhe_pkg::AMP_W; i++) begin
			if (a[i]) begin
				c = jhe_pkg::CAT_W'(i + 1);
			end
		end
		return c;
	endfunction

	logic                          fire;
	logic signed [11:0]            v;
	logic [11:0]                   neg_v;
	logic [11:0]                   vm1;
	logic [jhe_pkg::AMP_W-1:0]     mag;
	logic [jhe_pkg::AMP_W-1:0]     amp;
	logic [jhe_pkg::CAT_W-1:0]     cat;
	logic [jhe_pkg::CAT_W-1:0]     dc_cat;
	logic [3:0]                    run_c;
	logic [3:0]                    ac_cat;
	logic [DC_AW-1:0]              dc_raddr;
	logic [AC_AW-1:0]              ac_raddr;
	logic [jhe_pkg::LEN_W-1:0]     len_c;
	logic [ENT_W-1:0]              wentry;
	logic                          dc_we;
	logic                          ac_we;
	logic                          dc_re;
	logic                          ac_re;
	logic                          is_sym;
	logic [ENT_W-1:0]              dc_rdata;
	logic [ENT_W-1:0]              ac_rdata;
	logic [ENT_W-1:0]              rd;
	logic [jhe_pkg::LEN_W-1:0]     rd_len;

	logic                          valid_s1;
	jhe_pkg::kind_t                kind_s1;
	logic [jhe_pkg::AMP_W-1:0]     amp_s1;
	logic [jhe_pkg::CAT_W-1:0]     cat_s1;

	assign items.ready = !valid_s1 || push_ready;
	assign fire        = items.valid && items.ready;

	// Symbol classification on the incoming value.
	always_comb begin
		v      = (items.value == -12'sd2048) ? -12'sd2047 : items.value;
		neg_v  = -v;
		vm1    = v - 12'sd1;
		mag    = v[11] ? neg_v[jhe_pkg::AMP_W-1:0] : v[jhe_pkg::AMP_W-1:0];
		// A negative amplitude is sent as its low bits of value minus one.
		amp    = v[11] ? vm1[jhe_pkg::AMP_W-1:0] : v[jhe_pkg::AMP_W-1:0];
		cat    = bit_len(mag);
		dc_cat = (cat > jhe_pkg::DC_CAT_MAX) ? jhe_pkg::DC_CAT_MAX : cat;
		if (32'(dc_cat) < DC_TABLE_DEPTH) begin
			dc_raddr = DC_AW'(dc_cat);
		end else begin
			dc_raddr = DC_AW'(DC_TABLE_DEPTH - 1);
		end
		run_c  = (items.zero_run > 6'(jhe_pkg::RUN_MAX)) ? jhe_pkg::RUN_MAX
			: items.zero_run[3:0];
		ac_cat = (cat > jhe_pkg::AC_CAT_MAX) ? jhe_pkg::AC_CAT_MAX : cat;
		if (items.zero_run == 6'd0 && cat == '0) begin
			ac_raddr = '0;
		end else begin
			ac_raddr = AC_AW'({run_c, ac_cat});
		end
	end

	always_comb begin
		len_c  = (items.table_length > jhe_pkg::LEN_W'(MAX_CODE_LENGTH))
			? jhe_pkg::LEN_W'(MAX_CODE_LENGTH) : items.table_length;
		wentry = {len_c, items.table_code[MAX_CODE_LENGTH-1:0]};
		dc_we  = fire && items.cmd == jhe_pkg::CMD_LOAD_DC
			&& 32'(items.table_index) < DC_TABLE_DEPTH;
		ac_we  = fire && items.cmd == jhe_pkg::CMD_LOAD_AC;
		dc_re  = fire && items.cmd == jhe_pkg::CMD_ENC_DC;
		ac_re  = fire && items.cmd == jhe_pkg::CMD_ENC_AC;
		is_sym = items.cmd == jhe_pkg::CMD_ENC_DC || items.cmd == jhe_pkg::CMD_ENC_AC
			|| items.cmd == jhe_pkg::CMD_END;
	end

	jhe_ram #(.WIDTH(ENT_W), .DEPTH(DC_TABLE_DEPTH)) u_dc_table (
		.clk   (clk),
		.we    (dc_we),
		.waddr (items.table_index[DC_AW-1:0]),
		.wdata (wentry),
		.re    (dc_re),
		.raddr (dc_raddr),
		.rdata (dc_rdata)
	);

	jhe_ram #(.WIDTH(ENT_W), .DEPTH(AC_TABLE_DEPTH)) u_ac_table (
		.clk   (clk),
		.we    (ac_we),
		.waddr (items.table_index[AC_AW-1:0]),
		.wdata (wentry),
		.re    (ac_re),
		.raddr (ac_raddr),
		.rdata (ac_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire && is_sym) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_sym) begin
			case (items.cmd)
				jhe_pkg::CMD_ENC_DC: kind_s1 <= jhe_pkg::KIND_DC;
				jhe_pkg::CMD_ENC_AC: kind_s1 <= jhe_pkg::KIND_AC;
				default:             kind_s1 <= jhe_pkg::KIND_END;
			endcase
			amp_s1 <= amp;
			cat_s1 <= cat;
		end
	end

	// The table read data lines up with the symbol held in stage one.
	always_comb begin
		rd     = (kind_s1 == jhe_pkg::KIND_DC) ? dc_rdata : ac_rdata;
		rd_len = rd[ENT_W-1 -: jhe_pkg::LEN_W];
		push_valid       = valid_s1;
		push_data.is_end = kind_s1 == jhe_pkg::KIND_END;
		push_data.code   = jhe_pkg::CODE_W'(rd[MAX_CODE_LENGTH-1:0]);
		push_data.amp    = amp_s1;
		if (kind_s1 == jhe_pkg::KIND_END) begin
			push_data.code_len = '0;
			push_data.amp_len  = '0;
		end else if (kind_s1 == jhe_pkg::KIND_AC && rd_len == '0) begin
			// An unused AC entry writes nothing, not even the amplitude.
			push_data.code_len = '0;
			push_data.amp_len  = '0;
		end else begin
			push_data.code_len = rd_len;
			push_data.amp_len  = cat_s1;
		end
	end

endmodule

### design/jhe_queue.sv
// Short queue of classified symbols between the front and back ends.
// Depends on jhe_pkg.
module jhe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  jhe_pkg::qent_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output jhe_pkg::qent_t pop_data
);

	localparam int PW = $clog2(jhe_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(jhe_pkg::QUEUE_DEPTH + 1);

	jhe_pkg::qent_t slot_q [jhe_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != CW'(jhe_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/jhe_back.sv
// Back end: packs codes and amplitude bits MSB first, emits one byte per cycle
// unless stalled, ends blocks. Depends on jhe_pkg, jhe_out_if, defines header.
`include "jpeg_huffman_block_encoder_unit_defines.svh"

module jhe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  jhe_pkg::qent_t pop_data,
	jhe_out_if.source      results
);

	jhe_pkg::back_state_t          state_q;
	jhe_pkg::back_state_t          state_d;
	logic [jhe_pkg::ACC_W-1:0]     acc_q;
	logic [jhe_pkg::ACC_CW-1:0]    count_q;
	logic [jhe_pkg::PEND_W-1:0]    pend_bits_q;
	logic [2:0]                    pend_cnt_q;
	logic [jhe_pkg::CNT_W-1:0]     blk_bytes_q;

	logic                          out_valid_q;
	logic [7:0]                    byte_q;
	logic                          bvalid_q;
	logic                          last_q;
	logic                          done_q;
	logic [jhe_pkg::CNT_W-1:0]     cnt_q;

	logic                          out_free;
	logic                          do_pop;
	logic                          do_end;
	logic                          do_enc;
	logic                          do_emit;
	logic [5:0]                    sym_sh;
	logic [jhe_pkg::ACC_W-1:0]     cmask;
	logic [jhe_pkg::ACC_W-1:0]     amask;
	logic [jhe_pkg::ACC_W-1:0]     enc_acc;
	logic [jhe_pkg::ACC_CW-1:0]    enc_total;
	logic [jhe_pkg::ACC_CW-1:0]    rem;
	logic [jhe_pkg::ACC_W-1:0]     acc_sh;
	logic [7:0]                    emit_byte;
	logic                          emit_last;
	logic [jhe_pkg::PEND_W-1:0]    rem_bits;
	logic [7:0]                    end_byte;
	logic [jhe_pkg::CNT_W-1:0]     blk_inc;

	assign out_free = !out_valid_q || results.ready;

	// Datapath: join pending bits, code and amplitude, and form the output bytes.
	always_comb begin
		sym_sh    = 6'(pop_data.code_len) + 6'(pop_data.amp_len);
		cmask     = ~({jhe_pkg::ACC_W{1'b1}} << pop_data.code_len);
		amask     = ~({jhe_pkg::ACC_W{1'b1}} << pop_data.amp_len);
		enc_acc   = (jhe_pkg::ACC_W'(pend_bits_q) << sym_sh)
			| ((jhe_pkg::ACC_W'(pop_data.code) & cmask) << pop_data.amp_len)
			| (jhe_pkg::ACC_W'(pop_data.amp) & amask);
		enc_total = jhe_pkg::ACC_CW'(pend_cnt_q) + sym_sh;
		rem       = count_q - jhe_pkg::ACC_CW'(8);
		acc_sh    = acc_q >> rem;
		emit_byte = acc_sh[7:0];
		emit_last = rem < jhe_pkg::ACC_CW'(8);
		rem_bits  = acc_q[jhe_pkg::PEND_W-1:0] & ~({jhe_pkg::PEND_W{1'b1}} << rem[2:0]);
		end_byte  = 8'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
		blk_inc   = (blk_bytes_q < jhe_pkg::COUNT_MAX) ? blk_bytes_q + 10'd1 : blk_bytes_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jhe_pkg::ST_IDLE: begin
				if (pop_valid && !pop_data.is_end && enc_total >= jhe_pkg::ACC_CW'(8)) begin
					state_d = jhe_pkg::ST_EMIT;
				end
			end
			jhe_pkg::ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = jhe_pkg::ST_IDLE;
				end
			end
			default: state_d = jhe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		do_emit   = 1'b0;
		case (state_q)
			jhe_pkg::ST_IDLE: pop_ready = !pop_data.is_end || out_free;
			jhe_pkg::ST_EMIT: do_emit   = out_free;
			default: begin
				pop_ready = 1'b0;
				do_emit   = 1'b0;
			end
		endcase
		do_pop = pop_valid && pop_ready;
		do_end = do_pop && pop_data.is_end;
		do_enc = do_pop && !pop_data.is_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jhe_pkg::ST_IDLE;
			count_q     <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			blk_bytes_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_enc) begin
				count_q <= enc_total;
				if (enc_total < jhe_pkg::ACC_CW'(8)) begin
					pend_bits_q <= enc_acc[jhe_pkg::PEND_W-1:0];
					pend_cnt_q  <= enc_total[2:0];
				end
			end
			if (do_emit) begin
				count_q     <= rem;
				blk_bytes_q <= blk_inc;
				if (emit_last) begin
					pend_bits_q <= rem_bits;
					pend_cnt_q  <= rem[2:0];
				end
			end
			if (do_end) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				blk_bytes_q <= '0;
			end
			if (do_emit || do_end) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enc) begin
			acc_q <= enc_acc;
		end
		if (do_emit) begin
			byte_q   <= emit_byte;
			bvalid_q <= 1'b1;
			last_q   <= emit_last;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (do_end) begin
			byte_q   <= end_byte;
			bvalid_q <= pend_cnt_q != 3'd0;
			last_q   <= 1'b1;
			done_q   <= 1'b1;
			cnt_q    <= (pend_cnt_q != 3'd0) ? blk_inc : blk_bytes_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.out_byte         = byte_q;
	assign results.byte_valid       = bvalid_q;
	assign results.last             = last_q;
	assign results.block_done       = done_q;
	assign results.block_byte_count = cnt_q;

	`JHE_ASSERT_IMPL(a_emit_has_byte, clk, arst_n, state_q == jhe_pkg::ST_EMIT, count_q >= 6'd8)
	`JHE_ASSERT_IMPL(a_done_is_last, clk, arst_n, out_valid_q && done_q, last_q)
	`JHE_ASSERT_NEXT(a_end_clears, clk, arst_n, do_end, pend_cnt_q == 3'd0 && blk_bytes_q == 10'd0)
	`JHE_ASSERT_IMPL(a_pending_clean, clk, arst_n, state_q == jhe_pkg::ST_IDLE, (pend_bits_q >> pend_cnt_q) == 7'd0)

endmodule

### design/jpeg_huffman_block_encoder_unit.sv
// The packer takes no new symbol until it has emitted every byte of the previous
// one (none to four), limited by the single byte output register; the queue lets
// loads flow meanwhile.
// Reset clears the pending bits, byte count and handshakes; tables need loading.
module jpeg_huffman_block_encoder_unit #(
	parameter int AC_TABLE_DEPTH  = 256,
	parameter int DC_TABLE_DEPTH  = 12,
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	jhe_in_if.sink     items,
	jhe_out_if.source  results
);

	logic           push_valid;
	logic           push_ready;
	jhe_pkg::qent_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	jhe_pkg::qent_t pop_data;

	jhe_front #(
		.AC_TABLE_DEPTH  (AC_TABLE_DEPTH),
		.DC_TABLE_DEPTH  (DC_TABLE_DEPTH),
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	jhe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	jhe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

endmodule

### test/testbench.sv
// Testbench for the block Huffman encoder: table loads, DC and AC symbols and
// end-of-block items, each result byte checked against a predictor kept here.
// Depends on jhe_pkg, jhe_in_if, jhe_out_if and jpeg_huffman_block_encoder_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int DC_SLOTS = 12;
	localparam int AC_SLOTS = 256;
	localparam int MAX_LEN = 16;
	localparam int VALUE_LIMIT = 2047;
	localparam int TOTAL_ITEMS = 180;
	localparam int HOLD_START = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [7:0]         table_index;
		logic [15:0]        table_code;
		logic [4:0]         table_length;
		logic [5:0]         zero_run;
		logic signed [11:0] value;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       block_done;
		logic [9:0] block_byte_count;
	} stream_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jhe_in_if  items_if ();
	jhe_out_if results_if ();

	jpeg_huffman_block_encoder_unit #(
		.AC_TABLE_DEPTH (AC_SLOTS),
		.DC_TABLE_DEPTH (DC_SLOTS),
		.MAX_CODE_LENGTH(MAX_LEN)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(results_if)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Stimulus side bookkeeping: which table entries hold a code by now.
	item_t        pending_items[$];
	bit           dc_loaded[DC_SLOTS];
	bit           ac_loaded[AC_SLOTS];

	// Predictor state.
	logic [15:0]  dc_code[DC_SLOTS];
	logic [4:0]   dc_len[DC_SLOTS];
	logic [15:0]  ac_code[AC_SLOTS];
	logic [4:0]   ac_len[AC_SLOTS];
	logic [6:0]   held_bits = '0;
	int           held_count = 0;
	logic [9:0]   block_bytes = '0;
	stream_byte_t expected_bytes[$];

	int           failures = 0;
	int           accepted_items = 0;
	bit           in_taken = 1'b0;
	bit           out_taken = 1'b0;
	bit           offering = 1'b0;
	bit           send_calm = 1'b0;
	bit           take_calm = 1'b0;
	bit           hold_off = 1'b0;
	int           send_gap = 0;
	int           take_stall = 0;
	item_t        offered;

	function automatic int clamp_value(logic signed [11:0] raw);
		int v;
		v = raw;
		return (v < -VALUE_LIMIT) ? -VALUE_LIMIT : v;
	endfunction

	function automatic int size_class(int v);
		int a;
		int c;
		a = (v < 0) ? -v : v;
		c = 0;
		while (a != 0) begin
			c++;
			a = a >> 1;
		end
		return c;
	endfunction

	function automatic int dc_slot(int cat);
		int c;
		c = (cat > jhe_pkg::DC_CAT_MAX) ? int'(jhe_pkg::DC_CAT_MAX) : cat;
		return (c < DC_SLOTS) ? c : DC_SLOTS - 1;
	endfunction

	// Run 0 with value 0 is the end-of-block symbol in entry 0.
	function automatic int ac_slot(int run, int cat);
		int r;
		int c;
		if (run == 0 && cat == 0)
			return 0;
		r = (run > jhe_pkg::RUN_MAX) ? int'(jhe_pkg::RUN_MAX) : run;
		c = (cat > jhe_pkg::AC_CAT_MAX) ? int'(jhe_pkg::AC_CAT_MAX) : cat;
		return r * 16 + c;
	endfunction

	function automatic logic [63:0] append_bits(logic [63:0] acc, logic [31:0] bits, int len);
		logic [31:0] mask;
		if (len == 0)
			return acc;
		mask = (32'd1 << len) - 32'd1;
		return (acc << len) | 64'(bits & mask);
	endfunction

	function automatic int random_len();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(MAX_LEN + 1, 31);
		return $urandom_range(1, MAX_LEN);
	endfunction

	function automatic int pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, 14) - 7;
		if (r < 8)
			return int'($signed(12'($urandom)));
		if (r == 8)
			return VALUE_LIMIT;
		return -VALUE_LIMIT - 1;
	endfunction

	function automatic int pick_run();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(16, 63) : $urandom_range(0, 15);
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic push_other(logic [2:0] cmd);
		item_t it;
		it = item_t'(ITEM_W'({$urandom, $urandom}));
		it.cmd = cmd;
		pending_items.push_back(it);
	endtask

	task automatic push_load(logic [2:0] cmd, int idx, int code, int len);
		item_t it;
		it.cmd = cmd;
		it.table_index = idx[7:0];
		it.table_code = code[15:0];
		it.table_length = len[4:0];
		it.zero_run = 6'($urandom);
		it.value = 12'($urandom);
		pending_items.push_back(it);
		if (cmd == jhe_pkg::CMD_LOAD_DC && idx < DC_SLOTS)
			dc_loaded[idx] = 1'b1;
		if (cmd == jhe_pkg::CMD_LOAD_AC)
			ac_loaded[idx] = 1'b1;
	endtask

	// A symbol whose table entry was never written first gets a load of its own.
	task automatic push_symbol(logic [2:0] cmd, int run, int val);
		item_t it;
		int cat;
		int slot;
		cat = size_class(clamp_value(12'(val)));
		if (cmd == jhe_pkg::CMD_ENC_DC) begin
			slot = dc_slot(cat);
			if (!dc_loaded[slot])
				push_load(jhe_pkg::CMD_LOAD_DC, slot, $urandom, random_len());
		end else begin
			slot = ac_slot(run, cat);
			if (!ac_loaded[slot])
				push_load(jhe_pkg::CMD_LOAD_AC, slot, $urandom, random_len());
		end
		it = item_t'(ITEM_W'({$urandom, $urandom}));
		it.cmd = cmd;
		it.zero_run = run[5:0];
		it.value = 12'(val);
		pending_items.push_back(it);
	endtask

	function automatic void count_byte();
		if (block_bytes != jhe_pkg::COUNT_MAX)
			block_bytes++;
	endfunction

	function automatic void encode_item(item_t it);
		logic [63:0]  acc;
		logic [7:0]   widened;
		int           cnt;
		int           v;
		int           cat;
		int           slot;
		int           amp;
		int           len;
		stream_byte_t r;
		len = (it.table_length > MAX_LEN) ? MAX_LEN : it.table_length;
		r = '0;
		case (it.cmd)
			jhe_pkg::CMD_LOAD_DC: begin
				if (it.table_index < DC_SLOTS) begin
					dc_code[it.table_index] = it.table_code;
					dc_len[it.table_index] = len[4:0];
				end
			end
			jhe_pkg::CMD_LOAD_AC: begin
				ac_code[it.table_index] = it.table_code;
				ac_len[it.table_index] = len[4:0];
			end
			jhe_pkg::CMD_END: begin
				if (held_count != 0) begin
					widened = {1'b0, held_bits};
					r.out_byte = widened << (8 - held_count);
					r.byte_valid = 1'b1;
					count_byte();
				end
				r.last = 1'b1;
				r.block_done = 1'b1;
				r.block_byte_count = block_bytes;
				expected_bytes.push_back(r);
				held_bits = '0;
				held_count = 0;
				block_bytes = '0;
			end
			jhe_pkg::CMD_ENC_DC, jhe_pkg::CMD_ENC_AC: begin
				acc = 64'(held_bits);
				cnt = held_count;
				v = clamp_value(it.value);
				cat = size_class(v);
				amp = (v > 0) ? v : v + (1 << cat) - 1;
				if (it.cmd == jhe_pkg::CMD_ENC_DC) begin
					slot = dc_slot(cat);
					acc = append_bits(acc, 32'(dc_code[slot]), dc_len[slot]);
					cnt += dc_len[slot];
					acc = append_bits(acc, amp, cat);
					cnt += cat;
				end else begin
					slot = ac_slot(it.zero_run, cat);
					// An entry of length zero suppresses the amplitude as well.
					if (ac_len[slot] != 0) begin
						acc = append_bits(acc, 32'(ac_code[slot]), ac_len[slot]);
						cnt += ac_len[slot];
						acc = append_bits(acc, amp, cat);
						cnt += cat;
					end
				end
				while (cnt >= 8) begin
					r.out_byte = 8'(acc >> (cnt - 8));
					r.byte_valid = 1'b1;
					cnt -= 8;
					r.last = (cnt < 8);
					expected_bytes.push_back(r);
					count_byte();
				end
				held_count = cnt;
				held_bits = 7'(acc & ((64'd1 << cnt) - 64'd1));
			end
			default: ;
		endcase
	endfunction

	function automatic void report(string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// Monitor: predicts on every accepted item and checks every accepted result.
	always @(posedge clk) begin
		stream_byte_t got;
		stream_byte_t want;
		item_t        seen;
		in_taken = 1'b0;
		out_taken = 1'b0;
		if (arst_n) begin
			if (items_if.valid && items_if.ready) begin
				in_taken = 1'b1;
				accepted_items++;
				seen.cmd = items_if.cmd;
				seen.table_index = items_if.table_index;
				seen.table_code = items_if.table_code;
				seen.table_length = items_if.table_length;
				seen.zero_run = items_if.zero_run;
				seen.value = items_if.value;
				encode_item(seen);
			end
			if (results_if.valid && results_if.ready) begin
				out_taken = 1'b1;
				got.out_byte = results_if.out_byte;
				got.byte_valid = results_if.byte_valid;
				got.last = results_if.last;
				got.block_done = results_if.block_done;
				got.block_byte_count = results_if.block_byte_count;
				if (expected_bytes.size() == 0) begin
					report($sformatf("unexpected result: byte=%h valid=%b last=%b done=%b count=%0d",
						got.out_byte, got.byte_valid, got.last, got.block_done,
						got.block_byte_count));
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want)
						report($sformatf({"mismatch: expected byte=%h valid=%b last=%b done=%b ",
							"count=%0d, got byte=%h valid=%b last=%b done=%b count=%0d"},
							want.out_byte, want.byte_valid, want.last, want.block_done,
							want.block_byte_count, got.out_byte, got.byte_valid, got.last,
							got.block_done, got.block_byte_count));
				end
			end
		end
	end

	// Sender: offers queued items with a random gap after each accepted one.
	always @(negedge clk) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
		end else begin
			if (offering && in_taken) begin
				offering = 1'b0;
				if ($urandom_range(0, 19) == 0)
					send_calm = !send_calm;
				send_gap = draw_wait(send_calm);
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() != 0) begin
					offered = pending_items.pop_front();
					offering = 1'b1;
					items_if.cmd <= offered.cmd;
					items_if.table_index <= offered.table_index;
					items_if.table_code <= offered.table_code;
					items_if.table_length <= offered.table_length;
					items_if.zero_run <= offered.zero_run;
					items_if.value <= offered.value;
				end
			end
			items_if.valid <= offering;
		end
	end

	// Receiver: stalls a random number of cycles after each result.
	always @(negedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (out_taken) begin
				if ($urandom_range(0, 19) == 0)
					take_calm = !take_calm;
				take_stall = draw_wait(take_calm);
			end
			if (take_stall > 0) begin
				take_stall--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= !hold_off;
			end
		end
	end

	// One long hold-off of the receiver so that the encoder backs up into its input.
	initial begin
		while (accepted_items < HOLD_START)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int n_ac;
		int r;
		items_if.valid = 1'b0;
		items_if.cmd = jhe_pkg::CMD_LOAD_DC;
		items_if.table_index = '0;
		items_if.table_code = '0;
		items_if.table_length = '0;
		items_if.zero_run = '0;
		items_if.value = '0;
		results_if.ready = 1'b0;

		// Directed part: field extremes, clamps, ignored loads and empty entries.
		push_load(jhe_pkg::CMD_LOAD_DC, 0, 16'hFFFF, 0);
		push_load(jhe_pkg::CMD_LOAD_DC, 11, 16'hFFFF, 31);
		push_load(jhe_pkg::CMD_LOAD_DC, 255, 0, 5);
		push_load(jhe_pkg::CMD_LOAD_DC, DC_SLOTS, 1, 3);
		push_load(jhe_pkg::CMD_LOAD_AC, 0, 16'h000A, 4);
		push_load(jhe_pkg::CMD_LOAD_AC, 8'hF0, 16'h07F9, 11);
		push_load(jhe_pkg::CMD_LOAD_AC, 8'hFA, 16'hFFFE, 16);
		push_load(jhe_pkg::CMD_LOAD_AC, 8'h11, 16'h1234, 0);
		push_load(jhe_pkg::CMD_LOAD_AC, 255, 0, 16);
		push_symbol(jhe_pkg::CMD_ENC_DC, 0, 0);
		push_symbol(jhe_pkg::CMD_ENC_DC, 0, -VALUE_LIMIT - 1);
		push_symbol(jhe_pkg::CMD_ENC_DC, 63, VALUE_LIMIT);
		push_symbol(jhe_pkg::CMD_ENC_AC, 1, 1);
		push_symbol(jhe_pkg::CMD_ENC_AC, 63, -VALUE_LIMIT - 1);
		push_symbol(jhe_pkg::CMD_ENC_AC, 63, 0);
		push_symbol(jhe_pkg::CMD_ENC_AC, 0, 0);
		push_other(CMD_SPARE_LO);
		push_other(CMD_SPARE_HI);
		push_other(jhe_pkg::CMD_END);
		push_other(jhe_pkg::CMD_END);
		push_symbol(jhe_pkg::CMD_ENC_DC, 0, -1);
		push_other(jhe_pkg::CMD_END);

		// Random blocks: DC, a run of AC symbols, mostly an EOB and an end item,
		// with stray loads and unused commands mixed in.
		while (pending_items.size() < TOTAL_ITEMS) begin
			push_symbol(jhe_pkg::CMD_ENC_DC, $urandom_range(0, 63), pick_value());
			n_ac = $urandom_range(0, 10);
			repeat (n_ac) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					push_other(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
				else if (r == 1)
					push_load(jhe_pkg::CMD_LOAD_DC, $urandom_range(0, 15), $urandom,
						random_len());
				else if (r == 2)
					push_load(jhe_pkg::CMD_LOAD_AC, $urandom_range(0, 255), $urandom,
						random_len());
				push_symbol(jhe_pkg::CMD_ENC_AC, pick_run(), pick_value());
			end
			if ($urandom_range(0, 3) != 0)
				push_symbol(jhe_pkg::CMD_ENC_AC, 0, 0);
			if ($urandom_range(0, 7) != 0)
				push_other(jhe_pkg::CMD_END);
		end

		push_other(jhe_pkg::CMD_END);
		push_symbol(jhe_pkg::CMD_ENC_DC, 0, 3);
		push_other(jhe_pkg::CMD_END);
	end

	initial begin
		while (!arst_n || pending_items.size() != 0 || offering || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
